// ===== hdl/tal_pkg.sv =====
package tal_pkg;

    // Fixed field widths of the stream payloads.
    localparam int SAMPLE_W      = 12;
    localparam int TEMP_W        = 16;
    localparam int IN_TDATA_W    = 16;
    localparam int OUT_TDATA_W   = 32;
    localparam int OUT_PAD_W     = OUT_TDATA_W - TEMP_W - SAMPLE_W;

    // Every temperature of the curve and its magnitude fit in this many integer bits.
    localparam int TEMP_INT_BITS = 8;

    localparam int NUM_POINTS    = 19;
    localparam int SEG_W         = 5;
    localparam int DV_W          = 10;
    localparam int DIFF_W        = SAMPLE_W + 2;
    localparam int PROD_W        = DIFF_W + TEMP_INT_BITS + 1;
    localparam int NUM_W         = 24;

    localparam int FILTER_WEIGHT_SHIFT_DEF = 3;
    localparam int FRACTION_BITS_DEF       = 8;

    // Falling voltage/temperature curve of the thermistor divider.
    localparam int CURVE_DEG [NUM_POINTS] = '{
        0, 8, 10, 20, 24, 30, 35, 40, 45, 50,
        60, 65, 70, 75, 80, 90, 100, 125, 126
    };
    localparam int CURVE_VOLT [NUM_POINTS] = '{
        2800, 2710, 2660, 2260, 2120, 1914, 1809, 1706, 1602, 1519,
        1420, 1420, 730, 587, 527, 360, 235, 0, -1
    };

    typedef struct packed {
        logic load;
        logic search;
        logic mult;
        logic prep;
        logic div_step;
        logic write;
    } t_dp_cmd;

    // The segment ends at the first point whose voltage is below v; segment 1 at least.
    function automatic logic [SEG_W-1:0] find_segment(input logic [SAMPLE_W-1:0] v);
        int k;
        k = NUM_POINTS - 1;
        for (int i = NUM_POINTS - 1; i >= 0; i--) begin
            if (CURVE_VOLT[i] < int'(v)) begin
                k = i;
            end
        end
        if (k == 0) begin
            k = 1;
        end
        return SEG_W'(k);
    endfunction

    function automatic int seg_clamp(input logic [SEG_W-1:0] seg);
        int s;
        s = int'(seg);
        if (s < 1 || s >= NUM_POINTS) begin
            s = 1;
        end
        return s;
    endfunction

    function automatic logic [DV_W-1:0] seg_dv(input logic [SEG_W-1:0] seg);
        int s;
        s = seg_clamp(seg);
        return DV_W'(CURVE_VOLT[s-1] - CURVE_VOLT[s]);
    endfunction

    function automatic logic [TEMP_INT_BITS-1:0] seg_dt(input logic [SEG_W-1:0] seg);
        int s;
        s = seg_clamp(seg);
        return TEMP_INT_BITS'(CURVE_DEG[s] - CURVE_DEG[s-1]);
    endfunction

    function automatic logic [TEMP_INT_BITS-1:0] seg_ht(input logic [SEG_W-1:0] seg);
        int s;
        s = seg_clamp(seg);
        return TEMP_INT_BITS'(CURVE_DEG[s]);
    endfunction

    function automatic logic signed [DIFF_W-1:0] seg_hv(input logic [SEG_W-1:0] seg);
        int s;
        s = seg_clamp(seg);
        return DIFF_W'(CURVE_VOLT[s]);
    endfunction

    function automatic logic signed [NUM_W-1:0] seg_p(input logic [SEG_W-1:0] seg);
        int s;
        s = seg_clamp(seg);
        return NUM_W'(CURVE_DEG[s] * (CURVE_VOLT[s-1] - CURVE_VOLT[s]));
    endfunction

endpackage

// ===== hdl/thermistor_adc_linearizer_unit.sv =====
// Thermistor converter linearizer.
// Input stream: one 12-bit converter sample per beat in tdata[11:0]. The sample
// passes a one-pole smoothing filter, and the smoothed value is mapped to a
// temperature by linear interpolation on a fixed 19-point curve.
// Output stream: one beat per input beat with the signed Q8.8 temperature in
// tdata[15:0] and the smoothed sample in tdata[27:16].
// One item is in work at a time. After an input beat is taken, the block steps
// through segment search, multiply, divider setup, the division and the output
// write; the result beat is presented and the next input beat can be taken in
// the same cycle. The longest step is the restoring divider, which produces
// one quotient bit per cycle.
// The finished result sits in an output register; the next sample is taken and
// computed while it waits. If the receiver stalls past the end of that work,
// the block holds in its last step and accepts nothing until the register is
// free. Reset clears the filter accumulator, drops the output valid and returns
// the controller to idle, ready for a sample.
module thermistor_adc_linearizer_unit
    import tal_pkg::*;
#(
    parameter int FILTER_WEIGHT_SHIFT = FILTER_WEIGHT_SHIFT_DEF,
    parameter int FRACTION_BITS       = FRACTION_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,   // [11:0] adc_sample, [15:12] zero
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata    // [15:0] temperature_q8,
                                                     // [27:16] filtered_sample, [31:28] zero
);

    t_dp_cmd             w_cmd;
    logic [TEMP_W-1:0]   w_temp;
    logic [SAMPLE_W-1:0] w_filt;

    tal_ctrl #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_cmd       (w_cmd)
    );

    tal_dpath #(
        .FILTER_WEIGHT_SHIFT (FILTER_WEIGHT_SHIFT),
        .FRACTION_BITS       (FRACTION_BITS)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_sample (i_s_axis_tdata[SAMPLE_W-1:0]),
        .o_temp   (w_temp),
        .o_filt   (w_filt)
    );

    assign o_m_axis_tdata = {{OUT_PAD_W{1'b0}}, w_filt, w_temp};

endmodule

// ===== hdl/tal_ctrl.sv =====
module tal_ctrl
    import tal_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

    localparam int QW    = TEMP_INT_BITS + FRACTION_BITS;
    localparam int CNT_W = $clog2(QW);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_MULT,
        S_PREP,
        S_DIV,
        S_OUT
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   n_cnt;
    logic               r_out_valid;
    logic               n_out_valid;
    logic               w_accept;
    logic               w_write;

    // No beat is taken while reset is held.
    assign o_in_ready  = (r_state == S_IDLE) && i_rst_n;
    assign o_out_valid = r_out_valid;
    assign w_accept    = o_in_ready && i_in_valid;
    // The result register may be reloaded in the cycle its beat is taken.
    assign w_write     = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = w_accept;
        o_cmd.search   = (r_state == S_SEARCH);
        o_cmd.mult     = (r_state == S_MULT);
        o_cmd.prep     = (r_state == S_PREP);
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.write    = w_write;
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                n_state = S_MULT;
            end
            S_MULT: begin
                n_state = S_PREP;
            end
            S_PREP: begin
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(QW - 1)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_write) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== hdl/tal_dpath.sv =====
module tal_dpath
    import tal_pkg::*;
#(
    parameter int FILTER_WEIGHT_SHIFT = FILTER_WEIGHT_SHIFT_DEF,
    parameter int FRACTION_BITS       = FRACTION_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    input  logic [SAMPLE_W-1:0] i_sample,
    output logic [TEMP_W-1:0]   o_temp,
    output logic [SAMPLE_W-1:0] o_filt
);

    localparam int SUM_W = SAMPLE_W + FILTER_WEIGHT_SHIFT + 1;
    localparam int QW    = TEMP_INT_BITS + FRACTION_BITS;
    localparam int RES_W = QW + 1;
    localparam int EXT_W = (RES_W > TEMP_W) ? RES_W : TEMP_W + 1;
    localparam logic signed [EXT_W-1:0] SAT_MAX = EXT_W'(2 ** (TEMP_W - 1) - 1);
    localparam logic signed [EXT_W-1:0] SAT_MIN = EXT_W'(-(2 ** (TEMP_W - 1)));

    logic [SAMPLE_W-1:0]         r_acc;
    logic [SEG_W-1:0]            r_seg;
    logic signed [PROD_W-1:0]    r_q;
    logic signed [NUM_W-1:0]     r_p;
    logic [DV_W-1:0]             r_dv;
    logic [TEMP_INT_BITS-1:0]    r_ht;
    logic                        r_neg;
    logic [DV_W-1:0]             r_rem;
    logic [QW-1:0]               r_dq;
    logic [TEMP_W-1:0]           r_out_temp;
    logic [SAMPLE_W-1:0]         r_out_filt;

    logic [SAMPLE_W-1:0]         w_seed;
    logic [SUM_W-1:0]            w_sum;
    logic signed [DIFF_W-1:0]    w_diff;
    logic signed [PROD_W-1:0]    w_prod;
    logic signed [NUM_W-1:0]     w_num;
    logic [NUM_W-1:0]            w_mag;
    logic [DV_W:0]               w_trial;
    logic                        w_ge;
    logic signed [RES_W-1:0]     w_quo;
    logic signed [RES_W-1:0]     w_res;
    logic signed [EXT_W-1:0]     w_res_ext;
    logic [TEMP_W-1:0]           w_temp;

    // One-pole filter; an empty accumulator is seeded with the sample.
    assign w_seed = (r_acc == '0) ? i_sample : r_acc;
    assign w_sum  = SUM_W'(i_sample) + (SUM_W'(w_seed) << FILTER_WEIGHT_SHIFT)
                  - SUM_W'(w_seed);

    assign w_diff = $signed({2'b00, r_acc}) - seg_hv(r_seg);
    assign w_prod = PROD_W'(w_diff) * PROD_W'($signed({1'b0, seg_dt(r_seg)}));

    assign w_num  = r_p - NUM_W'(r_q);
    assign w_mag  = w_num[NUM_W-1] ? NUM_W'(-w_num) : NUM_W'(w_num);

    // Restoring division; the quotient magnitude stays below 2^QW, so the
    // high part of the dividend is already smaller than the divisor.
    assign w_trial = {r_rem, r_dq[QW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dv});

    assign w_quo = $signed({1'b0, r_dq});

    always_comb begin
        if (r_dv == '0) begin
            w_res = $signed({1'b0, r_ht, {FRACTION_BITS{1'b0}}});
        end else if (r_neg) begin
            w_res = -w_quo;
        end else begin
            w_res = w_quo;
        end
        w_res_ext = EXT_W'(w_res);
        if (w_res_ext > SAT_MAX) begin
            w_temp = SAT_MAX[TEMP_W-1:0];
        end else if (w_res_ext < SAT_MIN) begin
            w_temp = SAT_MIN[TEMP_W-1:0];
        end else begin
            w_temp = w_res_ext[TEMP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_cmd.load) begin
            r_acc <= w_sum[FILTER_WEIGHT_SHIFT +: SAMPLE_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.search) begin
            r_seg <= find_segment(r_acc);
        end
        if (i_cmd.mult) begin
            r_q  <= w_prod;
            r_p  <= seg_p(r_seg);
            r_dv <= seg_dv(r_seg);
            r_ht <= seg_ht(r_seg);
        end
        if (i_cmd.prep) begin
            r_neg <= w_num[NUM_W-1];
            r_rem <= w_mag[TEMP_INT_BITS +: DV_W];
            r_dq  <= {w_mag[TEMP_INT_BITS-1:0], {FRACTION_BITS{1'b0}}};
        end
        if (i_cmd.div_step) begin
            r_rem <= w_ge ? DV_W'(w_trial - {1'b0, r_dv}) : w_trial[DV_W-1:0];
            r_dq  <= {r_dq[QW-2:0], w_ge};
        end
        if (i_cmd.write) begin
            r_out_temp <= w_temp;
            r_out_filt <= r_acc;
        end
    end

    assign o_temp = r_out_temp;
    assign o_filt = r_out_filt;

endmodule

// ===== hdl/tal_checker.sv =====
module tal_checker
    import tal_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_axis_tvalid,
    input logic                   o_s_axis_tready,
    input logic                   o_m_axis_tvalid,
    input logic                   i_m_axis_tready,
    input logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    a_out_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result beat dropped while stalled");

    a_out_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("result beat changed while stalled");

    // Only one sample is in work at a time.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("second sample taken while one is in work");

    // The block becomes ready again only by handing over a finished result.
    a_ready_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_s_axis_tready) && $past(i_rst_n) |-> o_m_axis_tvalid)
        else $error("ready returned without a result");

endmodule

bind thermistor_adc_linearizer_unit tal_checker u_tal_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

// ===== sim/thermistor_adc_linearizer_unit_test.sv =====
`timescale 1ns / 1ps

module thermistor_adc_linearizer_unit_test;
    import tal_pkg::*;

    localparam int FILTER_SHIFT = 3;
    localparam int FRAC_BITS    = 8;
    localparam int CURVE_LEN    = 19;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SAMPLE_MAX   = (1 << SAMPLE_W) - 1;

    // Falling divider curve: degrees and converter counts, point by point.
    localparam int NTC_DEG [CURVE_LEN] = '{
        0, 8, 10, 20, 24, 30, 35, 40, 45, 50,
        60, 65, 70, 75, 80, 90, 100, 125, 126
    };
    localparam int NTC_CNT [CURVE_LEN] = '{
        2800, 2710, 2660, 2260, 2120, 1914, 1809, 1706, 1602, 1519,
        1420, 1420, 730, 587, 527, 360, 235, 0, -1
    };

    typedef struct packed {
        logic [SAMPLE_W-1:0]      filtered;
        logic signed [TEMP_W-1:0] temp_q8;
    } t_reading;

    logic                   i_clk;
    logic                   i_rst_n = 1'b0;
    logic                   s_valid = 1'b0;
    logic [IN_TDATA_W-1:0]  s_data  = '0;
    logic                   m_ready = 1'b0;
    logic                   s_ready;
    logic                   m_valid;
    logic [OUT_TDATA_W-1:0] m_data;

    logic [SAMPLE_W-1:0] pending_samples [$];
    t_reading            expected_readings [$];
    logic [SAMPLE_W-1:0] smooth_acc = '0;
    int                  sender_idle_pct = 0;
    int                  sink_stall_pct  = 0;
    int                  mismatches = 0;
    int                  cycle_count = 0;

    thermistor_adc_linearizer_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),   // [11:0] adc_sample, [15:12] zero
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)    // [15:0] temperature_q8, [27:16] filtered_sample,
                                     // [31:28] zero
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Advances the smoothing filter and maps the new value onto the curve.
    function automatic t_reading linearize_sample(input logic [SAMPLE_W-1:0] sample);
        int       blend;
        int       v;
        int       k;
        longint   lo_t, lo_v, hi_t, hi_v, span, quot;
        t_reading r;
        if (smooth_acc == 0) begin
            smooth_acc = sample;
        end
        blend = int'(sample) + int'(smooth_acc) * ((1 << FILTER_SHIFT) - 1);
        smooth_acc = SAMPLE_W'(blend >> FILTER_SHIFT);
        v = int'(smooth_acc);
        for (k = 0; k < CURVE_LEN; k++) begin
            if (NTC_CNT[k] < v) begin
                break;
            end
        end
        if (k == 0) begin
            k = 1;
        end
        if (k >= CURVE_LEN) begin
            k = CURVE_LEN - 1;
        end
        lo_t = NTC_DEG[k-1];
        lo_v = NTC_CNT[k-1];
        hi_t = NTC_DEG[k];
        hi_v = NTC_CNT[k];
        span = lo_v - hi_v;
        if (span == 0) begin
            quot = hi_t * (64'sd1 <<< FRAC_BITS);
        end else begin
            // Signed division truncates toward zero, as the output format wants.
            quot = ((hi_t * span - (hi_t - lo_t) * (longint'(v) - hi_v))
                    * (64'sd1 <<< FRAC_BITS)) / span;
        end
        if (quot > 32767) begin
            quot = 32767;
        end
        if (quot < -32768) begin
            quot = -32768;
        end
        r.temp_q8  = TEMP_W'(quot);
        r.filtered = smooth_acc;
        return r;
    endfunction

    function automatic void flag_mismatch(input t_reading exp_r,
                                          input logic [OUT_TDATA_W-1:0] got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch: temp exp %0d got %0d, filtered exp %0d got %0d, pad got %h",
                     exp_r.temp_q8, $signed(got[15:0]), exp_r.filtered, got[27:16],
                     got[OUT_TDATA_W-1:28]);
        end
    endfunction

    // Sample driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
            s_data  <= '0;
        end else begin
            if (s_valid && s_ready) begin
                expected_readings.push_back(linearize_sample(s_data[SAMPLE_W-1:0]));
            end
            if (!s_valid || s_ready) begin
                if (pending_samples.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    s_valid <= 1'b1;
                    s_data  <= IN_TDATA_W'(pending_samples.pop_front());
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        t_reading exp_r;
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_readings.size() == 0) begin
                    exp_r = '0;
                    flag_mismatch(exp_r, m_data);
                end else begin
                    exp_r = expected_readings.pop_front();
                    if (m_data[15:0] !== exp_r.temp_q8 || m_data[27:16] !== exp_r.filtered
                        || m_data[OUT_TDATA_W-1:28] !== '0) begin
                        flag_mismatch(exp_r, m_data);
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic push_sample(input int value);
        if (value < 0) begin
            value = 0;
        end
        if (value > SAMPLE_MAX) begin
            value = SAMPLE_MAX;
        end
        pending_samples.push_back(SAMPLE_W'(value));
    endtask

    // Mostly steady levels so the filter settles onto every segment, with
    // decays to zero that force a reload, and some raw noise.
    task automatic add_random_samples(input int count);
        int start_size;
        int mode;
        int level;
        int run_len;
        start_size = pending_samples.size();
        while (pending_samples.size() - start_size < count) begin
            mode = $urandom_range(11);
            if (mode < 4) begin
                level = NTC_CNT[$urandom_range(CURVE_LEN - 2)] + $urandom_range(40) - 20;
                run_len = $urandom_range(30, 6);
                repeat (run_len) push_sample(level + $urandom_range(16) - 8);
            end else if (mode < 8) begin
                level = $urandom_range(SAMPLE_MAX);
                run_len = $urandom_range(30, 4);
                repeat (run_len) push_sample(level + $urandom_range(64) - 32);
            end else if (mode < 9) begin
                run_len = $urandom_range(75, 40);
                repeat (run_len) push_sample(0);
            end else begin
                run_len = $urandom_range(8, 1);
                repeat (run_len) push_sample($urandom_range(SAMPLE_MAX));
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    sender_idle_pct = 0;
                    sink_stall_pct  = 0;
                end
                1: begin
                    sender_idle_pct = 74;
                    sink_stall_pct  = 0;
                end
                2: begin
                    sender_idle_pct = 0;
                    sink_stall_pct  = 74;
                end
                default: begin
                    sender_idle_pct = 16;
                    sink_stall_pct  = 16;
                end
            endcase
            if (ph == 0) begin
                // A zero sample with an empty filter stays zero and lands on the
                // last segment; a full-scale reload then sits above the first point.
                push_sample(0);
                push_sample(0);
                push_sample(SAMPLE_MAX);
                push_sample(SAMPLE_MAX);
                push_sample(SAMPLE_MAX);
                push_sample(2801);
                push_sample(2800);
                push_sample(12'hAAA);
                push_sample(12'h555);
                push_sample(1420);
                push_sample(730);
                push_sample(235);
                push_sample(1);
                push_sample(0);
                push_sample(SAMPLE_MAX);
                push_sample(0);
                push_sample(12'h800);
                push_sample(12'h7FF);
            end
            add_random_samples(155);
            while (pending_samples.size() != 0 || s_valid || expected_readings.size() != 0) begin
                @(posedge i_clk);
            end
        end

        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && expected_readings.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
